// File: design/assert_macros.svh
// Assertion macros used by the checker file srrt_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define SRRT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("srrt assertion failed");

// Check that also holds while reset is high.
`define SRRT_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("srrt assertion failed during reset");

`endif

// File: design/srrt_pkg.sv
// Shared constants, codes and the token type of the region remap table.
// No dependencies.
package srrt_pkg;

  localparam int ENTRIES = 8;
  localparam int DATA_W  = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SHIFT_W = 6;

  // item kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_LOOKUP = 2'd3;

  // result status
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ADDR_ERR = 2'd1;
  localparam logic [1:0] STATUS_CMD_ERR  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  // item travelling along the cell chain
  typedef struct packed {
    logic              vld;
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;   // write value, lookup base or read result
    logic [DATA_W-1:0] mask;
    logic              hit;
    logic [1:0]        status;
  } token_t;

endpackage

// File: design/srrt_cell.sv
// One cell of the remap chain: holds one descriptor and one token stage.
// Depends on srrt_pkg.
module srrt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [srrt_pkg::IDX_W-1:0]  cell_idx,
  input  srrt_pkg::token_t            tok_in,
  output srrt_pkg::token_t            tok_out
);

  logic [srrt_pkg::DATA_W-1:0] desc;
  srrt_pkg::token_t            tok_next;
  logic                        sel;
  logic                        hit_here;

  assign sel = (tok_in.idx == cell_idx);
  assign hit_here = (tok_in.op == srrt_pkg::OP_LOOKUP) && desc[0] &&
                    ((desc & tok_in.mask) == tok_in.data);

  always_comb begin
    tok_next = tok_in;
    tok_next.hit = tok_in.hit | hit_here;
    if ((tok_in.op == srrt_pkg::OP_READ) && sel) begin
      tok_next.data = desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc <= '0;
    end else if (advance && tok_in.vld && (tok_in.op == srrt_pkg::OP_WRITE) && sel) begin
      desc <= tok_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// File: design/stack_region_remap_table.sv
// Region remap table: ENTRIES 64-bit descriptors (srrt_pkg::ENTRIES, 8 here),
// each held in its own cell of a chain. An item is decoded on entry and then
// walks the chain one cell per cycle; every cell applies a write aimed at it,
// returns its descriptor to a read aimed at it, and ORs its match into a
// lookup. Items stay in order, so each item sees all earlier writes. The
// block takes one item per cycle unless the chain is held, and returns its
// result from the last cell; a stalled result holds the whole chain, so
// req_ready follows rsp_ready whenever the last cell holds a result. The
// descriptors reset to zero (all invalid). region_shift (APB address 0,
// reset 12) sets the region size; write it only while no item is in the
// chain. Stored descriptors keep the masking in force when they were written.
// Depends on srrt_pkg and srrt_cell.
module stack_region_remap_table (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  kind,
  input  logic [63:0] mmio_offset,
  input  logic [7:0]  access_bytes,
  input  logic [63:0] write_data,
  input  logic [63:0] lookup_address,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [63:0] read_data,
  output logic        hit,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ENTRIES = srrt_pkg::ENTRIES;
  localparam int DATA_W  = srrt_pkg::DATA_W;
  localparam int IDX_W   = srrt_pkg::IDX_W;

  logic [srrt_pkg::SHIFT_W-1:0] region_shift;
  logic [DATA_W-1:0]            mask;
  logic                         advance;
  logic                         addr_ok;
  srrt_pkg::token_t             entry_tok;
  srrt_pkg::token_t             chain [ENTRIES+1];

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_shift <= srrt_pkg::SHIFT_W'(12);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      region_shift <= pwdata[srrt_pkg::SHIFT_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32 - srrt_pkg::SHIFT_W){1'b0}}, region_shift};

  // region mask: all ones above the region size
  assign mask = {DATA_W{1'b1}} << region_shift;

  // ---------------- entry decode ----------------
  // mmio access must be 8 bytes, 8-byte aligned, and index a real entry
  assign addr_ok = (access_bytes == 8'd8) && (mmio_offset[2:0] == 3'd0) &&
                   ({3'd0, mmio_offset[63:3]} < DATA_W'(ENTRIES));

  always_comb begin
    entry_tok        = '0;
    entry_tok.vld    = req_valid;
    entry_tok.idx    = mmio_offset[3 +: IDX_W];
    entry_tok.mask   = mask;
    entry_tok.op     = srrt_pkg::OP_NONE;
    entry_tok.status = srrt_pkg::STATUS_OK;
    if (kind == srrt_pkg::KIND_LOOKUP) begin
      entry_tok.op   = srrt_pkg::OP_LOOKUP;
      entry_tok.data = lookup_address & mask;
    end else if (!addr_ok) begin
      entry_tok.status = srrt_pkg::STATUS_ADDR_ERR;
    end else if (kind == srrt_pkg::KIND_WRITE) begin
      entry_tok.op   = srrt_pkg::OP_WRITE;
      // valid bit always kept, address bits masked to the region
      entry_tok.data = (write_data & mask & ~DATA_W'(1)) | (write_data & DATA_W'(1));
    end else if (kind == srrt_pkg::KIND_READ) begin
      entry_tok.op   = srrt_pkg::OP_READ;
    end else begin
      entry_tok.status = srrt_pkg::STATUS_CMD_ERR;
    end
  end

  // ---------------- cell chain ----------------
  // whole chain moves together; it holds only when a result waits at the end
  assign advance   = !chain[ENTRIES].vld || rsp_ready;
  assign req_ready = advance;
  assign chain[0]  = entry_tok;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    srrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_idx (IDX_W'(i)),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
  end

  // ---------------- result ----------------
  assign rsp_valid = chain[ENTRIES].vld;
  assign status    = chain[ENTRIES].status;
  assign read_data = chain[ENTRIES].data & {DATA_W{chain[ENTRIES].op == srrt_pkg::OP_READ}};
  assign hit       = chain[ENTRIES].hit;

endmodule

// File: design/srrt_checker.sv
// Port-level checks for the region remap table, bound to the top level.
// Depends on srrt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [63:0] read_data,
  input logic        hit
);

  logic err_rsp;

  assign err_rsp = rsp_valid && (status != srrt_pkg::STATUS_OK);

  // reset empties the chain
  `SRRT_ASSERT_RST(a_reset_empty, clk, rst |=> !rsp_valid)

  // status is one of the three defined codes
  `SRRT_ASSERT(a_status_code, clk, rst, rsp_valid |-> (status <= srrt_pkg::STATUS_CMD_ERR))

  // a failed item carries neither data nor a hit
  `SRRT_ASSERT(a_err_quiet, clk, rst, err_rsp |-> (read_data == 64'd0 && !hit))

  // a held result stalls the whole chain, so no new item enters
  `SRRT_ASSERT(a_stall_blocks, clk, rst, (rsp_valid && !rsp_ready) |-> !req_ready)

  // a held result stays
  `SRRT_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> rsp_valid)

endmodule

bind stack_region_remap_table srrt_checker u_srrt_checker (.*);

// File: tb/stack_region_remap_table_tb.sv
// Self-checking testbench for the stack region remap table: mmio reads and
// writes, lookups and the region shift register. Depends on srrt_pkg and
// the stack_region_remap_table RTL only.
`timescale 1ns / 100ps

module stack_region_remap_table_tb;

  localparam int          CYCLE_LIMIT      = 400000;
  localparam logic [2:0]  REG_REGION_SHIFT = 3'd0;   // APB byte address of region_shift
  localparam logic [5:0]  SHIFT_AT_RESET   = 6'd12;

  // one response item as the block should return it
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic        hit;
  } remap_result_t;

  // clock, reset
  logic        clk = 1'b0;
  logic        rst = 1'b1;

  // request channel
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  kind = srrt_pkg::KIND_READ;
  logic [63:0] mmio_offset = '0;
  logic [7:0]  access_bytes = '0;
  logic [63:0] write_data = '0;
  logic [63:0] lookup_address = '0;

  // response channel
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] read_data;
  logic        hit;

  // APB
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the block state, advanced as each item is accepted
  logic [63:0]   shadow_table [srrt_pkg::ENTRIES];
  logic [5:0]    cur_shift = SHIFT_AT_RESET;
  remap_result_t pending_results [$];
  remap_result_t oldest_result;

  int unsigned cycle_count = 0;
  int unsigned fail_count  = 0;
  int unsigned burst_left  = 0;
  int unsigned ready_phase = 0;
  int unsigned stall_left  = 0;

  stack_region_remap_table dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // bits kept by the region mask; shift 0 keeps all bits, valid bit included
  function automatic logic [63:0] region_keep(input logic [5:0] shift);
    return ~64'h0 << shift;
  endfunction

  // Works out the response of one item and applies any table write.
  // The address check runs before the command decode for every mmio kind.
  function automatic remap_result_t predict_remap(input logic [1:0] item_kind,
                                                 input logic [63:0] off,
                                                 input logic [7:0] nbytes,
                                                 input logic [63:0] wdata,
                                                 input logic [63:0] laddr);
    remap_result_t               r;
    logic [63:0]                 keep;
    logic                        in_table;
    logic [srrt_pkg::IDX_W-1:0]  idx;
    r    = '0;
    keep = region_keep(cur_shift);
    if (item_kind == srrt_pkg::KIND_LOOKUP) begin
      for (int i = 0; i < srrt_pkg::ENTRIES; i++)
        if (shadow_table[i][0] && ((shadow_table[i] & keep) == (laddr & keep)))
          r.hit = 1'b1;
    end else begin
      // offset >> 3 compared as a whole: a huge offset cannot wrap into range
      in_table = (nbytes == 8'd8) && (off[2:0] == 3'd0) &&
                 (off[63:3] < srrt_pkg::ENTRIES);
      idx      = off[3 +: srrt_pkg::IDX_W];
      if (!in_table)
        r.status = srrt_pkg::STATUS_ADDR_ERR;
      else if (item_kind == srrt_pkg::KIND_WRITE)
        shadow_table[idx] = (wdata & keep & ~64'h1) | (wdata & 64'h1);
      else if (item_kind == srrt_pkg::KIND_READ)
        r.read_data = shadow_table[idx];
      else
        r.status = srrt_pkg::STATUS_CMD_ERR;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: rsp_ready pattern cycles through always-ready, light and
  // heavy random stalls, and rare long stalls
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else begin
      case (ready_phase[8:7])
        2'd0: rsp_ready <= 1'b1;
        2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
        2'd2: rsp_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(4, 20);
            rsp_ready  <= 1'b0;
          end else begin
            rsp_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Response checker: every accepted response against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response status %h read_data %h hit %b",
                 $time, status, read_data, hit);
        fail_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.status) begin
          $display("%0t: status expected %h got %h", $time, oldest_result.status, status);
          fail_count++;
        end
        if (read_data !== oldest_result.read_data) begin
          $display("%0t: read_data expected %h got %h",
                   $time, oldest_result.read_data, read_data);
          fail_count++;
        end
        if (hit !== oldest_result.hit) begin
          $display("%0t: hit expected %b got %b", $time, oldest_result.hit, hit);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender: bursts of random length with random gaps in between.
  // Called at a rising edge; returns at the edge where the item is taken.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [1:0] item_kind, input logic [63:0] off,
                           input logic [7:0] nbytes, input logic [63:0] wdata,
                           input logic [63:0] laddr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    req_valid      <= 1'b1;
    kind           <= item_kind;
    mmio_offset    <= off;
    access_bytes   <= nbytes;
    write_data     <= wdata;
    lookup_address <= laddr;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(predict_remap(item_kind, off, nbytes, wdata, laddr));
  endtask

  // Stop sending and wait until every predicted response has come back,
  // then let the chain run empty.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (srrt_pkg::ENTRIES + 2) @(posedge clk);
  endtask

  // APB write of region_shift, followed by a read back of the register
  task automatic set_region_shift(input logic [5:0] shift);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_REGION_SHIFT;
    pwdata  <= {26'd0, shift};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_shift = shift;
    // straight into the read: psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {26'd0, shift}) begin
      $display("%0t: region_shift read back expected %h got %h",
               $time, {26'd0, shift}, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Directed table accesses at the reset shift: empty table, extreme data,
  // every address error, the command error, and lookups hit and miss.
  task automatic test_table_access();
    send_item(srrt_pkg::KIND_READ,   64'd0,  8'd8, '0, '0);      // cleared entry
    send_item(srrt_pkg::KIND_LOOKUP, '0,     '0,   '0, 64'd0);   // all invalid, miss
    send_item(srrt_pkg::KIND_WRITE,  64'd0,  8'd8, ~64'h0, '0);  // low bits dropped
    send_item(srrt_pkg::KIND_WRITE,  64'd56, 8'd8, 64'h0000_0000_1234_5FFE, '0); // invalid
    send_item(srrt_pkg::KIND_READ,   64'd0,  8'd8, '0, '0);
    send_item(srrt_pkg::KIND_READ,   64'd56, 8'd8, '0, '0);
    send_item(srrt_pkg::KIND_LOOKUP, '0,     '0,   '0, 64'hFFFF_FFFF_FFFF_F123);
    send_item(srrt_pkg::KIND_LOOKUP, '0,     '0,   '0, 64'h0000_0000_1234_5678);
    send_item(srrt_pkg::KIND_WRITE,  64'd8,  8'd8, 64'h8000_0000_0000_0001, '0);
    send_item(srrt_pkg::KIND_LOOKUP, '0,     '0,   '0, 64'h8000_0000_0000_0FFF);
    // wrong length
    send_item(srrt_pkg::KIND_READ,   64'd0,  8'd0,   '0, '0);
    send_item(srrt_pkg::KIND_READ,   64'd0,  8'd7,   '0, '0);
    send_item(srrt_pkg::KIND_WRITE,  64'd16, 8'd9,   ~64'h0, '0);
    send_item(srrt_pkg::KIND_READ,   64'd0,  8'd255, '0, '0);
    // misaligned; the write must leave entry 0 alone
    send_item(srrt_pkg::KIND_READ,   64'd4,  8'd8, '0, '0);
    send_item(srrt_pkg::KIND_WRITE,  64'd1,  8'd8, 64'h0, '0);
    send_item(srrt_pkg::KIND_READ,   64'd0,  8'd8, '0, '0);
    // past the end, including an offset where offset + 8 would wrap
    send_item(srrt_pkg::KIND_READ,   64'd64, 8'd8, '0, '0);
    send_item(srrt_pkg::KIND_WRITE,  64'hFFFF_FFFF_FFFF_FFF8, 8'd8, ~64'h0, '0);
    // other command: command error only when the address is good
    send_item(srrt_pkg::KIND_OTHER,  64'd16, 8'd8, '0, '0);
    send_item(srrt_pkg::KIND_OTHER,  64'd3,  8'd8, '0, '0);
    send_item(srrt_pkg::KIND_OTHER,  64'd16, 8'd4, '0, '0);
    // lookup ignores garbage in the mmio fields
    send_item(srrt_pkg::KIND_LOOKUP, ~64'h0, 8'd255, ~64'h0, ~64'h0);
  endtask

  // Zero shift puts the valid bit into the compare; stored descriptors keep
  // the mask they were written with. Then the widest region, shift 63.
  task automatic test_shift_extremes();
    set_region_shift(6'd0);
    send_item(srrt_pkg::KIND_WRITE,  64'd16, 8'd8, 64'hDEAD_BEEF_0000_0003, '0);
    send_item(srrt_pkg::KIND_LOOKUP, '0, '0, '0, 64'hDEAD_BEEF_0000_0003); // hit
    send_item(srrt_pkg::KIND_LOOKUP, '0, '0, '0, 64'hDEAD_BEEF_0000_0002); // bit 0 clear
    send_item(srrt_pkg::KIND_LOOKUP, '0, '0, '0, ~64'h0);   // old entry 0 masked at 12
    send_item(srrt_pkg::KIND_WRITE,  64'd24, 8'd8, ~64'h0, '0);
    send_item(srrt_pkg::KIND_LOOKUP, '0, '0, '0, ~64'h0);   // hit
    send_item(srrt_pkg::KIND_READ,   64'd16, 8'd8, '0, '0);
    set_region_shift(6'd63);
    send_item(srrt_pkg::KIND_LOOKUP, '0, '0, '0, 64'h8000_0000_0000_0000);
    send_item(srrt_pkg::KIND_LOOKUP, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(srrt_pkg::KIND_WRITE,  64'd32, 8'd8, 64'h7FFF_FFFF_FFFF_FFFF, '0); // bit 0 only
    send_item(srrt_pkg::KIND_READ,   64'd32, 8'd8, '0, '0);
    send_item(srrt_pkg::KIND_LOOKUP, '0, '0, '0, 64'h0000_0000_0000_0000);
  endtask

  // Random traffic at one shift. Lookups are mostly aimed at stored
  // descriptors so that hits are common; some accesses are malformed.
  // Halfway through, the sender waits for every response to come back.
  task automatic test_random_traffic(input logic [5:0] shift, input int unsigned count);
    int unsigned                sel;
    int unsigned                pick;
    logic [1:0]                 item_kind;
    logic [63:0]                off;
    logic [7:0]                 nbytes;
    logic [63:0]                laddr;
    logic [63:0]                keep;
    logic [srrt_pkg::IDX_W-1:0] entry_pick;
    set_region_shift(shift);
    keep = region_keep(shift);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2)
        drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 40)      item_kind = srrt_pkg::KIND_LOOKUP;
      else if (sel < 65) item_kind = srrt_pkg::KIND_WRITE;
      else if (sel < 88) item_kind = srrt_pkg::KIND_READ;
      else               item_kind = srrt_pkg::KIND_OTHER;

      pick = $urandom_range(0, 9);
      if (pick < 8)
        off = 64'($urandom_range(0, srrt_pkg::ENTRIES - 1)) << 3;
      else if (pick == 8)
        off = rand64();
      else
        off = (64'($urandom_range(0, srrt_pkg::ENTRIES - 1)) << 3) |
              64'($urandom_range(0, 7));
      nbytes = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd8;

      laddr = rand64();
      if (item_kind == srrt_pkg::KIND_LOOKUP && $urandom_range(0, 9) < 6) begin
        // same region as a stored descriptor, random offset within it
        entry_pick = srrt_pkg::IDX_W'($urandom_range(0, srrt_pkg::ENTRIES - 1));
        laddr = shadow_table[entry_pick] ^ (rand64() & ~keep);
        if ($urandom_range(0, 9) == 0)
          laddr[6'($urandom_range(shift, 63))] ^= 1'b1;    // near miss
      end
      send_item(item_kind, off, nbytes, rand64(), laddr);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    for (int i = 0; i < srrt_pkg::ENTRIES; i++) shadow_table[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_access();
    test_shift_extremes();

    test_random_traffic(SHIFT_AT_RESET, 300);
    test_random_traffic(6'd0, 250);
    test_random_traffic(6'd63, 250);
    test_random_traffic(6'd1, 250);
    test_random_traffic(6'($urandom_range(0, 63)), 250);
    test_random_traffic(6'd62, 250);
    test_random_traffic(6'($urandom_range(2, 40)), 250);

    // all sent: wait out the last responses and the pipeline depth
    drain_results();
    repeat (4 * srrt_pkg::ENTRIES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
